// ===== rtl/core/spi_pkg.sv =====
// ----------------------------------------------------------------------------
// spi_pkg
// shared types and constants of the two-axis servo pulse interpolator
// ----------------------------------------------------------------------------
package spi_pkg;

   // request kinds
   localparam logic [1:0] REQ_SET_ANGLE = 2'd0;
   localparam logic [1:0] REQ_SET_US    = 2'd1;
   localparam logic [1:0] REQ_SMOOTH    = 2'd2;
   localparam logic [1:0] REQ_TICK      = 2'd3;

   // control register indexes
   localparam logic [1:0] CSR_PULSE_MIN = 2'd0;
   localparam logic [1:0] CSR_PULSE_MAX = 2'd1;

   localparam logic [14:0] PULSE_MIN_RESET   = 15'd500;
   localparam logic [14:0] PULSE_MAX_RESET   = 15'd2500;
   localparam logic [14:0] AXIS_COMPARE_INIT = 15'd1500;

   localparam logic [7:0]  DEG_MAX     = 8'd180;
   localparam logic [15:0] MOVE_MS_MIN = 16'd10;
   localparam logic [14:0] TICK_MS     = 15'd20;

   // shared divider sizes
   localparam int DIV_DW = 23;
   localparam int DIV_SW = 15;
   localparam int DIV_CW = $clog2(DIV_DW + 1);

   typedef struct packed {
      logic              start;
      logic [DIV_DW-1:0] dividend;
      logic [DIV_SW-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic              done;
      logic [DIV_DW-1:0] quotient;
   } div_rsp_type;

endpackage

// ===== rtl/core/spi_div.sv =====
// ----------------------------------------------------------------------------
// spi_div
// restoring serial divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module spi_div
   import spi_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_req_type div_req,
   output div_rsp_type div_rsp
);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [DIV_CW-1:0] count_ff, count_in;
   logic [DIV_SW-1:0] rem_ff, rem_in;
   logic [DIV_DW-1:0] quo_ff, quo_in;
   logic [DIV_SW-1:0] divisor_ff, divisor_in;

   logic [DIV_SW:0]   trial;
   logic [DIV_SW:0]   diff;
   logic              fits;

   always_comb begin
      trial      = {rem_ff, quo_ff[DIV_DW-1]};
      diff       = trial - {1'b0, divisor_ff};
      fits       = (trial >= {1'b0, divisor_ff});
      busy_in    = busy_ff;
      done_in    = 1'b0;
      count_in   = count_ff;
      rem_in     = rem_ff;
      quo_in     = quo_ff;
      divisor_in = divisor_ff;
      if (div_req.start) begin
         busy_in    = 1'b1;
         count_in   = DIV_CW'(DIV_DW);
         rem_in     = '0;
         quo_in     = div_req.dividend;
         divisor_in = div_req.divisor;
      end else if (busy_ff) begin
         rem_in   = fits ? diff[DIV_SW-1:0] : trial[DIV_SW-1:0];
         quo_in   = {quo_ff[DIV_DW-2:0], fits};
         count_in = count_ff - 1'b1;
         if (count_ff == DIV_CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff     <= rem_in;
      quo_ff     <= quo_in;
      divisor_ff <= divisor_in;
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff;

endmodule

// ===== rtl/core/servo_pulse_interpolator_core.sv =====
// ----------------------------------------------------------------------------
// servo_pulse_interpolator_core
// two-axis servo pulse-width compare values with smooth angle moves
// ----------------------------------------------------------------------------
// request beats (req_*) carry set-angle, set-microseconds, smooth-move or
// 20 ms tick commands; each gives zero or one response beat (rsp_*) with the
// new compare value of one axis. csr_* writes pulse_min_us / pulse_max_us
// and is always ready; write it only while the block is idle.
// one request is worked on at a time: req_stall is high from acceptance
// until the response is loaded into the output register. all divisions go
// through one shared serial divider. set-microseconds needs no divide,
// set-angle one, a tick up to two (one interpolation divide and one
// angle-to-width divide) and a smooth move up to four.
// a pending response is held while rsp_stall is high; the next request is
// still accepted and waits in its last step until the output is free.
// reset clears both compare values to 1500 us, the limits to 500 / 2500 us
// and cancels any move.
// ----------------------------------------------------------------------------
module servo_pulse_interpolator_core
   import spi_pkg::*;
(
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_type,
   input  logic        req_axis_sel,
   input  logic [7:0]  req_angle_deg,
   input  logic [15:0] req_pulse_us,
   input  logic [15:0] req_move_ms,

   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_out_axis,
   output logic [14:0] rsp_compare_us,
   output logic        rsp_moving,
   output logic        rsp_move_last,

   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [14:0] csr_data
);

   typedef enum logic [10:0] {
      S_IDLE    = 11'b000_0000_0001,
      S_STEPS   = 11'b000_0000_0010,
      S_STEPS_W = 11'b000_0000_0100,
      S_PRES    = 11'b000_0000_1000,
      S_PRES_W  = 11'b000_0001_0000,
      S_SETUP   = 11'b000_0010_0000,
      S_ADV     = 11'b000_0100_0000,
      S_ADV_W   = 11'b000_1000_0000,
      S_US      = 11'b001_0000_0000,
      S_US_W    = 11'b010_0000_0000,
      S_DONE    = 11'b100_0000_0000
   } state_type;

   state_type    state_ff, state_in;

   logic [14:0]  pulse_min_ff, pulse_min_in;
   logic [14:0]  pulse_max_ff, pulse_max_in;
   logic [14:0]  axis_compare_ff [2];
   logic [14:0]  axis_compare_in [2];

   logic         move_active_ff, move_active_in;
   logic         move_axis_ff, move_axis_in;
   logic [7:0]   move_start_ff, move_start_in;
   logic         move_neg_ff, move_neg_in;
   logic [7:0]   move_mag_ff, move_mag_in;
   logic [7:0]   move_target_ff, move_target_in;
   logic [11:0]  move_total_ff, move_total_in;
   logic [12:0]  move_index_ff, move_index_in;

   logic         item_axis_ff, item_axis_in;
   logic [7:0]   item_ang_ff, item_ang_in;
   logic [15:0]  item_ms_ff, item_ms_in;
   logic [7:0]   deg_ff, deg_in;

   logic         res_axis_ff, res_axis_in;
   logic [14:0]  res_value_ff, res_value_in;
   logic         res_moving_ff, res_moving_in;
   logic         res_last_ff, res_last_in;

   logic         rsp_valid_ff, rsp_valid_in;
   logic         rsp_axis_ff, rsp_axis_in;
   logic [14:0]  rsp_value_ff, rsp_value_in;
   logic         rsp_moving_ff, rsp_moving_in;
   logic         rsp_last_ff, rsp_last_in;

   div_req_type  div_req;
   div_rsp_type  div_rsp;

   spi_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   always_comb begin
      logic [14:0]        span;
      logic [11:0]        n_div;
      logic [14:0]        cmp_sel;
      logic [7:0]         mul_a;
      logic [14:0]        mul_b;
      logic [DIV_DW-1:0]  product;
      logic [DIV_DW-1:0]  addend;
      logic [7:0]         ang_clamped;
      logic [15:0]        us_clamped;
      logic [7:0]         q8;
      logic               out_free;

      span    = (pulse_max_ff > pulse_min_ff) ? (pulse_max_ff - pulse_min_ff) : '0;
      n_div   = (move_total_ff == '0) ? 12'd1 : move_total_ff;
      cmp_sel = axis_compare_ff[item_axis_ff];
      q8      = div_rsp.quotient[7:0];
      out_free = !rsp_valid_ff || !rsp_stall;

      // shared multiplier in front of the divider load
      unique case (state_ff)
         S_PRES: begin
            mul_a = DEG_MAX;
            mul_b = cmp_sel - pulse_min_ff;
         end
         S_ADV: begin
            mul_a = move_mag_ff;
            mul_b = {2'b00, move_index_ff};
         end
         default: begin
            mul_a = deg_ff;
            mul_b = span;
         end
      endcase
      product = {15'd0, mul_a} * {8'd0, mul_b};
      addend  = (state_ff == S_ADV && move_neg_ff) ?
                {11'd0, n_div - 12'd1} : '0;

      div_req.start    = 1'b0;
      div_req.dividend = (state_ff == S_STEPS) ? {7'd0, item_ms_ff} : product + addend;
      unique case (state_ff)
         S_STEPS: div_req.divisor = TICK_MS;
         S_PRES:  div_req.divisor = span;
         S_ADV:   div_req.divisor = {3'd0, n_div};
         default: div_req.divisor = {7'd0, DEG_MAX};
      endcase

      ang_clamped = (req_angle_deg > DEG_MAX) ? DEG_MAX : req_angle_deg;
      us_clamped  = req_pulse_us;
      if (us_clamped < {1'b0, pulse_min_ff}) us_clamped = {1'b0, pulse_min_ff};
      if (us_clamped > {1'b0, pulse_max_ff}) us_clamped = {1'b0, pulse_max_ff};

      state_in           = state_ff;
      pulse_min_in       = pulse_min_ff;
      pulse_max_in       = pulse_max_ff;
      axis_compare_in[0] = axis_compare_ff[0];
      axis_compare_in[1] = axis_compare_ff[1];
      move_active_in     = move_active_ff;
      move_axis_in       = move_axis_ff;
      move_start_in      = move_start_ff;
      move_neg_in        = move_neg_ff;
      move_mag_in        = move_mag_ff;
      move_target_in     = move_target_ff;
      move_total_in      = move_total_ff;
      move_index_in      = move_index_ff;
      item_axis_in       = item_axis_ff;
      item_ang_in        = item_ang_ff;
      item_ms_in         = item_ms_ff;
      deg_in             = deg_ff;
      res_axis_in        = res_axis_ff;
      res_value_in       = res_value_ff;
      res_moving_in      = res_moving_ff;
      res_last_in        = res_last_ff;
      rsp_valid_in       = rsp_valid_ff && rsp_stall;
      rsp_axis_in        = rsp_axis_ff;
      rsp_value_in       = rsp_value_ff;
      rsp_moving_in      = rsp_moving_ff;
      rsp_last_in        = rsp_last_ff;

      if (csr_valid) begin
         unique case (csr_index)
            CSR_PULSE_MIN: pulse_min_in = csr_data;
            CSR_PULSE_MAX: pulse_max_in = csr_data;
            default: ;
         endcase
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               item_axis_in = req_axis_sel;
               item_ang_in  = ang_clamped;
               item_ms_in   = (req_move_ms < MOVE_MS_MIN) ? MOVE_MS_MIN : req_move_ms;
               res_axis_in  = req_axis_sel;
               unique case (req_type)
                  REQ_SET_ANGLE: begin
                     move_active_in = 1'b0;
                     deg_in         = ang_clamped;
                     res_moving_in  = 1'b0;
                     res_last_in    = 1'b0;
                     state_in       = S_US;
                  end
                  REQ_SET_US: begin
                     move_active_in = 1'b0;
                     res_value_in   = us_clamped[14:0];
                     res_moving_in  = 1'b0;
                     res_last_in    = 1'b0;
                     state_in       = S_DONE;
                  end
                  REQ_SMOOTH: begin
                     state_in = S_STEPS;
                  end
                  REQ_TICK: begin
                     res_axis_in = move_axis_ff;
                     if (move_active_ff) state_in = S_ADV;
                  end
                  default: ;
               endcase
            end
         end
         S_STEPS: begin
            div_req.start = 1'b1;
            state_in      = S_STEPS_W;
         end
         S_STEPS_W: begin
            if (div_rsp.done) begin
               move_total_in = (div_rsp.quotient == '0) ? 12'd1 : div_rsp.quotient[11:0];
               state_in      = S_PRES;
            end
         end
         S_PRES: begin
            if (span == '0 || cmp_sel <= pulse_min_ff) begin
               move_start_in = '0;
               state_in      = S_SETUP;
            end else begin
               div_req.start = 1'b1;
               state_in      = S_PRES_W;
            end
         end
         S_PRES_W: begin
            if (div_rsp.done) begin
               move_start_in = (div_rsp.quotient > {15'd0, DEG_MAX}) ? DEG_MAX : q8;
               state_in      = S_SETUP;
            end
         end
         S_SETUP: begin
            move_axis_in   = item_axis_ff;
            move_target_in = item_ang_ff;
            if (item_ang_ff >= move_start_ff) begin
               move_neg_in = 1'b0;
               move_mag_in = item_ang_ff - move_start_ff;
            end else begin
               move_neg_in = 1'b1;
               move_mag_in = move_start_ff - item_ang_ff;
            end
            move_index_in  = 13'd1;
            move_active_in = 1'b1;
            res_axis_in    = item_axis_ff;
            state_in       = S_ADV;
         end
         S_ADV: begin
            if (move_index_ff <= {1'b0, move_total_ff}) begin
               div_req.start = 1'b1;
               state_in      = S_ADV_W;
            end else begin
               move_active_in = 1'b0;
               deg_in         = move_target_ff;
               res_moving_in  = 1'b0;
               res_last_in    = 1'b1;
               state_in       = S_US;
            end
         end
         S_ADV_W: begin
            if (div_rsp.done) begin
               if (!move_neg_ff) begin
                  deg_in = move_start_ff + q8;
               end else if (div_rsp.quotient >= {15'd0, move_start_ff}) begin
                  deg_in = '0;
               end else begin
                  deg_in = move_start_ff - q8;
               end
               move_index_in = move_index_ff + 13'd1;
               res_moving_in = 1'b1;
               res_last_in   = 1'b0;
               state_in      = S_US;
            end
         end
         S_US: begin
            if (span == '0) begin
               res_value_in = pulse_min_ff;
               state_in     = S_DONE;
            end else begin
               div_req.start = 1'b1;
               state_in      = S_US_W;
            end
         end
         S_US_W: begin
            if (div_rsp.done) begin
               res_value_in = pulse_min_ff + div_rsp.quotient[14:0];
               state_in     = S_DONE;
            end
         end
         S_DONE: begin
            if (out_free) begin
               rsp_valid_in                 = 1'b1;
               rsp_axis_in                  = res_axis_ff;
               rsp_value_in                 = res_value_ff;
               rsp_moving_in                = res_moving_ff;
               rsp_last_in                  = res_last_ff;
               axis_compare_in[res_axis_ff] = res_value_ff;
               state_in                     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff           <= S_IDLE;
         pulse_min_ff       <= PULSE_MIN_RESET;
         pulse_max_ff       <= PULSE_MAX_RESET;
         axis_compare_ff[0] <= AXIS_COMPARE_INIT;
         axis_compare_ff[1] <= AXIS_COMPARE_INIT;
         move_active_ff     <= 1'b0;
         move_axis_ff       <= 1'b0;
         move_start_ff      <= '0;
         move_neg_ff        <= 1'b0;
         move_mag_ff        <= '0;
         move_target_ff     <= '0;
         move_total_ff      <= '0;
         move_index_ff      <= '0;
         rsp_valid_ff       <= 1'b0;
      end else begin
         state_ff           <= state_in;
         pulse_min_ff       <= pulse_min_in;
         pulse_max_ff       <= pulse_max_in;
         axis_compare_ff[0] <= axis_compare_in[0];
         axis_compare_ff[1] <= axis_compare_in[1];
         move_active_ff     <= move_active_in;
         move_axis_ff       <= move_axis_in;
         move_start_ff      <= move_start_in;
         move_neg_ff        <= move_neg_in;
         move_mag_ff        <= move_mag_in;
         move_target_ff     <= move_target_in;
         move_total_ff      <= move_total_in;
         move_index_ff      <= move_index_in;
         rsp_valid_ff       <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_axis_ff  <= item_axis_in;
      item_ang_ff   <= item_ang_in;
      item_ms_ff    <= item_ms_in;
      deg_ff        <= deg_in;
      res_axis_ff   <= res_axis_in;
      res_value_ff  <= res_value_in;
      res_moving_ff <= res_moving_in;
      res_last_ff   <= res_last_in;
      rsp_axis_ff   <= rsp_axis_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_moving_ff <= rsp_moving_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign req_stall      = (state_ff != S_IDLE);
   assign csr_ready      = 1'b1;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_axis   = rsp_axis_ff;
   assign rsp_compare_us = rsp_value_ff;
   assign rsp_moving     = rsp_moving_ff;
   assign rsp_move_last  = rsp_last_ff;

endmodule
